/* rtl/core/frf_pkg.sv */
package frf_pkg;

   // CRC-16, reflected polynomial, all-ones seed
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Register reset values: one preheader byte, '['
   localparam logic [63:0] PATTERN_RESET = 64'h0000_0000_0000_005B;
   localparam logic [3:0]  PRELEN_RESET  = 4'd1;
   localparam logic [3:0]  PRELEN_MAX    = 4'd8;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRELEN  = 1'd1;

   // Result word kinds
   typedef enum logic [2:0] {
      KIND_KEY  = 3'd0,
      KIND_DATA = 3'd1,
      KIND_GOOD = 3'd2,
      KIND_BAD  = 3'd3,
      KIND_DROP = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type   out_kind;
      logic [7:0] out_byte;
      logic [7:0] out_index;
      logic [5:0] key_length;
      logic [8:0] data_length;
   } rsp_item_type;

   // Parser to output buffer
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } push_type;

endpackage

/* rtl/core/frf_req_if.sv */
interface frf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/frf_rsp_if.sv */
interface frf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_kind;
   logic [7:0] out_byte;
   logic [7:0] out_index;
   logic [5:0] key_length;
   logic [8:0] data_length;

   modport source (output valid, output out_kind, output out_byte, output out_index,
                   output key_length, output data_length, input ready);
   modport sink (input valid, input out_kind, input out_byte, input out_index,
                 input key_length, input data_length, output ready);
endinterface

/* rtl/core/frf_csr_if.sv */
interface frf_csr_if;
   import frf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [63:0]          wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/core/frf_crc.sv */
module frf_crc (
   input  logic [15:0] seed,
   input  logic [7:0]  data,
   output logic [15:0] crc
);
   import frf_pkg::*;

   // Fold one byte in, eight shift steps, LSB first
   always_comb begin
      logic [15:0] acc;
      acc = seed ^ {8'd0, data};
      for (int i = 0; i < 8; i++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc = acc;
   end

endmodule

/* rtl/core/frf_parser.sv */
module frf_parser #(
   parameter int MAX_KEY  = 32,
   parameter int MAX_DATA = 256
) (
   input  logic               clock,
   input  logic               reset,
   frf_req_if.sink            req,
   frf_csr_if.sink            csr,
   input  logic               push_ready,
   output frf_pkg::push_type  push
);
   import frf_pkg::*;

   localparam int KLEN_W   = $clog2(MAX_KEY + 1);
   localparam int DLEN_RAW = $clog2(MAX_DATA + 1);
   localparam int DLEN_W   = (DLEN_RAW > 8) ? DLEN_RAW : 8;
   localparam int CNT_W    = DLEN_W;
   localparam int CNT1_W   = CNT_W + 1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_PRECHK,
      PH_KEYLEN,
      PH_DATALEN,
      PH_KEY,
      PH_DATA,
      PH_CHECKSUM
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        crc_low_ff, crc_low_in;
   logic [KLEN_W-1:0] klen_ff, klen_in;
   logic [DLEN_W-1:0] dlen_ff, dlen_in;
   logic              mism_ff, mism_in;
   logic [63:0]       pattern_ff;
   logic [3:0]        prelen_ff;

   logic              accept;
   logic [7:0]        rx;
   logic [3:0]        eff_prelen;
   logic [7:0]        pat_byte;
   logic [15:0]       crc_seed;
   logic [15:0]       crc_out;
   logic [CNT1_W-1:0] cnt_inc;
   logic [15:0]       dlen_full;
   logic [KLEN_W+5:0] klen_ext;
   logic [DLEN_W+8:0] dlen_ext;
   logic [CNT_W+7:0]  cnt_ext;
   push_type          push_in;

   function automatic logic [15:0] reseed(input logic [15:0] value);
      return (value == 16'd0) ? CRC_INIT : value;
   endfunction

   assign accept    = req.valid && req.ready;
   assign rx        = req.rx_byte;
   assign req.ready = push_ready;
   assign csr.ready = 1'b1;

   // Clamp preheader length to one..eight
   assign eff_prelen = (prelen_ff == 4'd0) ? 4'd1 :
                       (prelen_ff > PRELEN_MAX) ? PRELEN_MAX : prelen_ff;
   assign pat_byte   = pattern_ff[{cnt_ff[2:0], 3'b000} +: 8];

   // Seed: fresh for a preheader start, re-seeded at a length segment start
   always_comb begin
      if (phase_ff == PH_HUNT) begin
         crc_seed = CRC_INIT;
      end else if (phase_ff == PH_KEYLEN ||
                   (phase_ff == PH_DATALEN && cnt_ff == '0)) begin
         crc_seed = reseed(crc_ff);
      end else begin
         crc_seed = crc_ff;
      end
   end

   frf_crc u_crc (
      .seed (crc_seed),
      .data (rx),
      .crc  (crc_out)
   );

   assign cnt_inc   = CNT1_W'(cnt_ff) + CNT1_W'(1);
   assign dlen_full = {rx, dlen_ff[7:0]};
   assign klen_ext  = {6'd0, klen_ff};
   assign dlen_ext  = {9'd0, dlen_ff};
   assign cnt_ext   = {8'd0, cnt_ff};

   // Next state and result word for the accepted byte
   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      klen_in    = klen_ff;
      dlen_in    = dlen_ff;
      mism_in    = mism_ff;
      push_in.valid                  = 1'b0;
      push_in.item.out_kind          = KIND_DROP;
      push_in.item.out_byte          = 8'd0;
      push_in.item.out_index         = 8'd0;
      push_in.item.key_length        = 6'd0;
      push_in.item.data_length       = 9'd0;
      if (accept) begin
         case (phase_ff)
            PH_PRECHK: begin
               mism_in = mism_ff || (rx != pat_byte);
               crc_in  = crc_out;
               cnt_in  = cnt_inc[CNT_W-1:0];
               if (cnt_inc >= CNT1_W'(eff_prelen)) begin
                  phase_in = mism_in ? PH_HUNT : PH_KEYLEN;
                  cnt_in   = '0;
               end
            end
            PH_KEYLEN: begin
               cnt_in = '0;
               if (rx > 8'(MAX_KEY)) begin
                  phase_in      = PH_HUNT;
                  push_in.valid = 1'b1;
               end else begin
                  klen_in  = KLEN_W'(rx);
                  crc_in   = crc_out;
                  phase_in = PH_DATALEN;
               end
            end
            PH_DATALEN: begin
               crc_in = crc_out;
               if (cnt_ff == '0) begin
                  dlen_in = DLEN_W'(rx);
                  cnt_in  = CNT_W'(1);
               end else if (dlen_full > 16'(MAX_DATA)) begin
                  phase_in      = PH_HUNT;
                  cnt_in        = '0;
                  push_in.valid = 1'b1;
               end else begin
                  // Start key segment, or skip it when empty
                  dlen_in = DLEN_W'(dlen_full);
                  crc_in  = reseed(crc_out);
                  cnt_in  = '0;
                  if (klen_ff != '0) begin
                     phase_in = PH_KEY;
                  end else begin
                     phase_in = (dlen_full != 16'd0) ? PH_DATA : PH_CHECKSUM;
                  end
               end
            end
            PH_KEY: begin
               push_in.valid            = 1'b1;
               push_in.item.out_kind    = KIND_KEY;
               push_in.item.out_byte    = rx;
               push_in.item.out_index   = cnt_ext[7:0];
               push_in.item.key_length  = klen_ext[5:0];
               push_in.item.data_length = dlen_ext[8:0];
               crc_in = crc_out;
               cnt_in = cnt_inc[CNT_W-1:0];
               if (cnt_inc >= CNT1_W'(klen_ff)) begin
                  crc_in   = reseed(crc_out);
                  cnt_in   = '0;
                  phase_in = (dlen_ff != '0) ? PH_DATA : PH_CHECKSUM;
               end
            end
            PH_DATA: begin
               push_in.valid            = 1'b1;
               push_in.item.out_kind    = KIND_DATA;
               push_in.item.out_byte    = rx;
               push_in.item.out_index   = cnt_ext[7:0];
               push_in.item.key_length  = klen_ext[5:0];
               push_in.item.data_length = dlen_ext[8:0];
               crc_in = crc_out;
               cnt_in = cnt_inc[CNT_W-1:0];
               if (cnt_inc >= CNT1_W'(dlen_ff)) begin
                  cnt_in   = '0;
                  phase_in = PH_CHECKSUM;
               end
            end
            PH_CHECKSUM: begin
               if (cnt_ff == '0) begin
                  crc_low_in = rx;
                  cnt_in     = CNT_W'(1);
               end else begin
                  cnt_in   = '0;
                  phase_in = PH_HUNT;
                  push_in.valid            = 1'b1;
                  push_in.item.out_kind    = ({rx, crc_low_ff} == crc_ff) ? KIND_GOOD : KIND_BAD;
                  push_in.item.key_length  = klen_ext[5:0];
                  push_in.item.data_length = dlen_ext[8:0];
               end
            end
            default: begin
               // Hunt for the first preheader byte
               cnt_in = '0;
               if (rx == pattern_ff[7:0]) begin
                  crc_in  = crc_out;
                  mism_in = 1'b0;
                  if (eff_prelen == 4'd1) begin
                     phase_in = PH_KEYLEN;
                  end else begin
                     cnt_in   = CNT_W'(1);
                     phase_in = PH_PRECHK;
                  end
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   assign push = push_in;

   // Hold parse state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         cnt_ff     <= '0;
         crc_ff     <= CRC_INIT;
         crc_low_ff <= 8'd0;
         klen_ff    <= '0;
         dlen_ff    <= '0;
         mism_ff    <= 1'b0;
         pattern_ff <= PATTERN_RESET;
         prelen_ff  <= PRELEN_RESET;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
         klen_ff    <= klen_in;
         dlen_ff    <= dlen_in;
         mism_ff    <= mism_in;
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_PATTERN: pattern_ff <= csr.wdata;
               CSR_PRELEN:  prelen_ff  <= csr.wdata[3:0];
               default: ;
            endcase
         end
      end
   end

endmodule

/* rtl/core/frf_rsp_buf.sv */
module frf_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  frf_pkg::push_type push,
   output logic              push_ready,
   frf_rsp_if.source         rsp
);
   import frf_pkg::*;

   rsp_item_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop        = rsp.valid && rsp.ready;
   assign push_ready = (count_ff != 2'd2);

   // Present the oldest word
   assign rsp.valid       = (count_ff != 2'd0);
   assign rsp.out_kind    = mem_ff[rd_ptr_ff].out_kind;
   assign rsp.out_byte    = mem_ff[rd_ptr_ff].out_byte;
   assign rsp.out_index   = mem_ff[rd_ptr_ff].out_index;
   assign rsp.key_length  = mem_ff[rd_ptr_ff].key_length;
   assign rsp.data_length = mem_ff[rd_ptr_ff].data_length;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> count_ff != 2'd2)
      else $error("word pushed into full response buffer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response buffer count out of range");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("response buffer count lost a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("response buffer pointers disagree with count");
`endif

endmodule

/* rtl/core/crc16_frame_receiver_top.sv */
// Byte-serial receiver for preheader-framed packets checked by a CRC-16
// (reflected polynomial 0xA001, seed 0xFFFF). One received byte is taken per
// clock cycle while the output buffer has room: each byte is parsed and folded into
// the running CRC by a single byte-wide XOR network in the cycle it is
// accepted, and any key byte, data byte or end-of-frame status word lands in a
// two-word output buffer that the response side drains. Input stalls only when
// that buffer holds two words. Zero key or data lengths skip their segment;
// key lengths above MAX_KEY or data lengths above MAX_DATA drop the frame with
// a status word. Registers (preheader pattern, preheader length) take effect
// at once and should be written while the receiver is idle.
module crc16_frame_receiver_top #(
   parameter int MAX_KEY  = 32,
   parameter int MAX_DATA = 256
) (
   input  logic      clock,
   input  logic      reset,
   frf_req_if.sink   req_bus,
   frf_rsp_if.source rsp_bus,
   frf_csr_if.sink   csr_bus
);
   import frf_pkg::*;

   push_type push;
   logic     push_ready;

   frf_parser #(
      .MAX_KEY  (MAX_KEY),
      .MAX_DATA (MAX_DATA)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr        (csr_bus),
      .push_ready (push_ready),
      .push       (push)
   );

   frf_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .rsp        (rsp_bus)
   );

endmodule
